// ===== hdl/owik_pkg.sv =====
`default_nettype none

package owik_pkg;

   localparam int WHEEL_COUNT  = 4;
   localparam int CORDIC_STEPS = 16;
   localparam int QDEPTH       = 2;
   localparam int QPTR_W       = $clog2(QDEPTH);
   localparam int QCNT_W       = $clog2(QDEPTH + 1);
   localparam int TERM_COUNT   = 5;
   localparam int TIDX_W       = $clog2(TERM_COUNT);

   // heading scale: about 2^40 / (125000 * pi)
   localparam logic [21:0]        HDG_K         = 22'd2799883;
   localparam logic [55:0]        HDG_HALF      = 56'd1 << 39;
   localparam logic [15:0]        HEADING_RESET = 16'd57344;
   localparam logic [15:0]        OCTANT_BIAS   = 16'd8192;
   localparam logic [14:0]        OFFSET_RESET  = 15'd2048;
   localparam logic signed [31:0] CORDIC_GAIN   = 32'sd652032875;
   localparam logic signed [51:0] ROUND_HALF    = 52'sd536870912;
   localparam logic signed [21:0] OUT_MAX       = 22'sd131071;
   localparam logic signed [21:0] OUT_MIN       = -22'sd131072;

   // one queued command with its precomputed turn_rate * elapsed_us
   typedef struct packed {
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] turn_rate;
      logic signed [39:0] wt;
      logic               no_turn;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HLO,
      ST_HHI,
      ST_HSUM,
      ST_RINIT,
      ST_ROT,
      ST_MUL,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MSEL_HLO,
      MSEL_HHI,
      MSEL_S0VX,
      MSEL_C0VX,
      MSEL_S0VY,
      MSEL_C0VY,
      MSEL_SPIN
   } mul_sel_type;

   typedef struct packed {
      logic        pop;
      mul_sel_type mul_sel;
      logic        load_rsp;
   } back_ctrl_type;

   // arctan(2^-i) in units of 2^-24 turn
   function automatic logic signed [23:0] atan_lut(input logic [3:0] idx);
      logic signed [23:0] a;
      unique case (idx)
         4'd0:  a = 24'sd2097152;
         4'd1:  a = 24'sd1238021;
         4'd2:  a = 24'sd654136;
         4'd3:  a = 24'sd332050;
         4'd4:  a = 24'sd166669;
         4'd5:  a = 24'sd83416;
         4'd6:  a = 24'sd41718;
         4'd7:  a = 24'sd20860;
         4'd8:  a = 24'sd10430;
         4'd9:  a = 24'sd5215;
         4'd10: a = 24'sd2608;
         4'd11: a = 24'sd1304;
         4'd12: a = 24'sd652;
         4'd13: a = 24'sd326;
         4'd14: a = 24'sd163;
         4'd15: a = 24'sd81;
      endcase
      return a;
   endfunction

   // Q.42 sum -> Q.12, round half up, clamp to 18 bits
   function automatic logic signed [17:0] round_sat(input logic signed [51:0] acc);
      logic signed [51:0] r;
      logic signed [21:0] v;
      logic signed [17:0] res;
      r = acc + ROUND_HALF;
      v = r[51:30];
      priority if (v > OUT_MAX) begin
         res = OUT_MAX[17:0];
      end else if (v < OUT_MIN) begin
         res = OUT_MIN[17:0];
      end else begin
         res = v[17:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/owik_req_if.sv =====
`default_nettype none

interface owik_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   logic signed [15:0] turn_rate;
   logic [23:0]        elapsed_us;

   modport source (output valid, vel_x, vel_y, turn_rate, elapsed_us, input ready);
   modport sink   (input valid, vel_x, vel_y, turn_rate, elapsed_us, output ready);
endinterface

`default_nettype wire

// ===== hdl/owik_rsp_if.sv =====
`default_nettype none

interface owik_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] wheel_right_front;
   logic signed [17:0] wheel_left_front;
   logic signed [17:0] wheel_left_back;
   logic signed [17:0] wheel_right_back;
   logic [15:0]        heading_now;

   modport source (output valid, wheel_right_front, wheel_left_front, wheel_left_back,
                   wheel_right_back, heading_now, input ready);
   modport sink   (input valid, wheel_right_front, wheel_left_front, wheel_left_back,
                   wheel_right_back, heading_now, output ready);
endinterface

`default_nettype wire

// ===== hdl/owik_csr_if.sv =====
`default_nettype none

interface owik_csr_if;
   logic        valid;
   logic        ready;
   logic [14:0] wheel_offset;

   modport source (output valid, wheel_offset, input ready);
   modport sink   (input valid, wheel_offset, output ready);
endinterface

`default_nettype wire

// ===== hdl/owik_front.sv =====
`default_nettype none

module owik_front
   import owik_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   owik_req_if.sink      req,
   input  q_status_type  q_status,
   output logic          push,
   output entry_type     push_entry
);

   logic               front_vld_ff, front_vld_in;
   entry_type          entry_ff, entry_in;
   logic               accept;
   logic signed [40:0] wt_full;

   assign push      = front_vld_ff && !q_status.full;
   assign req.ready = !front_vld_ff || push;
   assign accept    = req.valid && req.ready;

   always_comb begin
      wt_full            = req.turn_rate * $signed({1'b0, req.elapsed_us});
      entry_in.vel_x     = req.vel_x;
      entry_in.vel_y     = req.vel_y;
      entry_in.turn_rate = req.turn_rate;
      entry_in.wt        = wt_full[39:0];
      // no turn or no elapsed time: heading update can be skipped
      entry_in.no_turn   = (wt_full == '0);
   end

   always_comb begin
      if (accept) begin
         front_vld_in = 1'b1;
      end else if (push) begin
         front_vld_in = 1'b0;
      end else begin
         front_vld_in = front_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
      end else begin
         front_vld_ff <= front_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

   assign push_entry = entry_ff;

endmodule

`default_nettype wire

// ===== hdl/owik_queue.sv =====
`default_nettype none

module owik_queue
   import owik_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output q_status_type q_status,
   output entry_type    head
);

   entry_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] n;
      if (p == QPTR_W'(QDEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign q_status.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign q_status.empty = (cnt_ff == '0);
   assign head           = mem_ff[rd_ptr_ff];

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0)
      else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== hdl/owik_back.sv =====
`default_nettype none

module owik_back
   import owik_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  entry_type    head,
   output logic         pop,
   input  logic [14:0]  wheel_offset,
   owik_rsp_if.source   rsp
);

   state_type          state_ff, state_in;
   back_ctrl_type      ctrl;
   logic [3:0]         cnt_ff, cnt_in;

   logic signed [15:0] vx_ff, vy_ff, w_ff;
   logic signed [39:0] wt_ff;
   logic [15:0]        heading_ff, heading_in;
   logic [41:0]        plo_ff;
   logic signed [55:0] prod_ff;
   logic signed [31:0] x_ff, y_ff;
   logic signed [23:0] z_ff;
   logic [1:0]         q_ff;
   logic signed [47:0] term_ff [TERM_COUNT];
   logic signed [51:0] acc_ff [WHEEL_COUNT];
   logic signed [51:0] acc_in [WHEEL_COUNT];

   logic               rsp_vld_ff, rsp_vld_in;
   logic signed [17:0] wheel_ff [WHEEL_COUNT];
   logic [15:0]        heading_out_ff;

   logic signed [32:0] mul_a;
   logic signed [22:0] mul_b;
   logic signed [55:0] mul_p;

   logic [55:0]        hsum;
   logic [15:0]        hdg_bias;
   logic [1:0]         q_new;
   logic [15:0]        resid;
   logic signed [31:0] dx, dy;
   logic signed [23:0] atan_i;
   logic signed [48:0] base0, base1, sel;
   logic signed [51:0] spin_sh;
   logic [1:0]         quad;

   // ---------------- control ----------------
   always_comb begin
      ctrl.pop      = (state_ff == ST_IDLE) && !q_status.empty;
      ctrl.load_rsp = (state_ff == ST_OUT) && (!rsp_vld_ff || rsp.ready);
      ctrl.mul_sel  = MSEL_SPIN;
      unique case (state_ff)
         ST_HLO: ctrl.mul_sel = MSEL_HLO;
         ST_HHI: ctrl.mul_sel = MSEL_HHI;
         ST_MUL: begin
            unique case (cnt_ff)
               4'd0:    ctrl.mul_sel = MSEL_S0VX;
               4'd1:    ctrl.mul_sel = MSEL_C0VX;
               4'd2:    ctrl.mul_sel = MSEL_S0VY;
               4'd3:    ctrl.mul_sel = MSEL_C0VY;
               default: ctrl.mul_sel = MSEL_SPIN;
            endcase
         end
         default: ctrl.mul_sel = MSEL_SPIN;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.pop) begin
               state_in = head.no_turn ? ST_RINIT : ST_HLO;
            end
         end
         ST_HLO:   state_in = ST_HHI;
         ST_HHI:   state_in = ST_HSUM;
         ST_HSUM:  state_in = ST_RINIT;
         ST_RINIT: state_in = ST_ROT;
         ST_ROT: begin
            if (cnt_ff == 4'(CORDIC_STEPS - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (cnt_ff == 4'(TERM_COUNT)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: state_in = ST_OUT;
         ST_OUT: begin
            if (ctrl.load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = '0;
      if ((state_ff == ST_ROT && cnt_ff != 4'(CORDIC_STEPS - 1)) || state_ff == ST_MUL) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (ctrl.load_rsp) begin
         rsp_vld_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
         heading_ff <= HEADING_RESET;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rsp_vld_ff <= rsp_vld_in;
         heading_ff <= heading_in;
      end
   end

   assign pop = ctrl.pop;

   // ---------------- shared multiplier ----------------
   always_comb begin
      unique case (ctrl.mul_sel)
         MSEL_HLO: begin
            mul_a = $signed({13'd0, wt_ff[19:0]});
            mul_b = $signed({1'b0, HDG_K});
         end
         MSEL_HHI: begin
            mul_a = {{13{wt_ff[39]}}, wt_ff[39:20]};
            mul_b = $signed({1'b0, HDG_K});
         end
         MSEL_S0VX: begin
            mul_a = {y_ff[31], y_ff};
            mul_b = {{7{vx_ff[15]}}, vx_ff};
         end
         MSEL_C0VX: begin
            mul_a = {x_ff[31], x_ff};
            mul_b = {{7{vx_ff[15]}}, vx_ff};
         end
         MSEL_S0VY: begin
            mul_a = {y_ff[31], y_ff};
            mul_b = {{7{vy_ff[15]}}, vy_ff};
         end
         MSEL_C0VY: begin
            mul_a = {x_ff[31], x_ff};
            mul_b = {{7{vy_ff[15]}}, vy_ff};
         end
         MSEL_SPIN: begin
            mul_a = $signed({18'd0, wheel_offset});
            mul_b = {{7{w_ff[15]}}, w_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // ---------------- heading ----------------
   // product is wt * K modulo 2^56, rebuilt from two 20-bit halves of wt
   always_comb begin
      hsum       = {prod_ff[35:0], 20'd0} + {14'd0, plo_ff} + HDG_HALF;
      heading_in = heading_ff;
      if (state_ff == ST_HSUM) begin
         heading_in = heading_ff + hsum[55:40];
      end
      hdg_bias = heading_ff + OCTANT_BIAS;
      q_new    = hdg_bias[15:14];
      resid    = heading_ff - {q_new, 14'd0};
   end

   // ---------------- CORDIC step ----------------
   always_comb begin
      dx     = y_ff >>> cnt_ff;
      dy     = x_ff >>> cnt_ff;
      atan_i = atan_lut(cnt_ff);
   end

   // ---------------- wheel sums ----------------
   // per wheel quadrant k: 0: -s*vx+c*vy, 1: -c*vx-s*vy, 2 and 3 negate those
   always_comb begin
      base0   = 49'(term_ff[3]) - 49'(term_ff[0]);
      base1   = -(49'(term_ff[1]) + 49'(term_ff[2]));
      spin_sh = 52'(term_ff[4]) <<< 18;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         quad = q_ff + 2'(i);
         unique case (quad)
            2'd0: sel = base0;
            2'd1: sel = base1;
            2'd2: sel = -base0;
            2'd3: sel = -base1;
         endcase
         acc_in[i] = 52'(sel) + spin_sh;
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      if (ctrl.pop) begin
         vx_ff <= head.vel_x;
         vy_ff <= head.vel_y;
         w_ff  <= head.turn_rate;
         wt_ff <= head.wt;
      end
      if (state_ff == ST_HHI) begin
         plo_ff <= prod_ff[41:0];
      end
      if (state_ff == ST_RINIT) begin
         x_ff <= CORDIC_GAIN;
         y_ff <= '0;
         z_ff <= $signed({resid, 8'd0});
         q_ff <= q_new;
      end
      if (state_ff == ST_ROT) begin
         if (!z_ff[23]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_i;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_i;
         end
      end
      if (state_ff == ST_MUL && cnt_ff != '0) begin
         term_ff[cnt_ff[TIDX_W-1:0] - 1'b1] <= prod_ff[47:0];
      end
      if (state_ff == ST_SUM) begin
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            acc_ff[i] <= acc_in[i];
         end
      end
      if (ctrl.load_rsp) begin
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            wheel_ff[i] <= round_sat(acc_ff[i]);
         end
         heading_out_ff <= heading_ff;
      end
   end

   assign rsp.valid             = rsp_vld_ff;
   assign rsp.wheel_right_front = wheel_ff[0];
   assign rsp.wheel_left_front  = wheel_ff[1];
   assign rsp.wheel_left_back   = wheel_ff[2];
   assign rsp.wheel_right_back  = wheel_ff[3];
   assign rsp.heading_now       = heading_out_ff;

`ifndef ASSERT_OFF
   a_heading_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(heading_ff)) |-> $past(state_ff) == ST_HSUM)
      else $error("heading changed outside update step");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside output step");

   a_rot_to_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT && cnt_ff == 4'(CORDIC_STEPS - 1))
         |=> (state_ff == ST_MUL && cnt_ff == '0))
      else $error("CORDIC did not hand off to multiply phase");

   a_pop_start: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |=> (state_ff == ST_HLO || state_ff == ST_RINIT))
      else $error("popped transaction not started");
`endif

endmodule

`default_nettype wire

// ===== hdl/omni_wheel_inverse_kinematics_unit.sv =====
`default_nettype none

// Omni-wheel inverse kinematics: each req transaction (global vx, vy, turn rate,
// elapsed microseconds) first advances the internal heading (binary angle, reset
// 57344 = -pi/4) by turn_rate * elapsed, then produces one rsp transaction with four
// saturated Q5.12 wheel speeds at 90 degree spacing and the new heading. An input
// stage and a two-deep queue take up to three commands while the back end works.
// The back end takes one command at a time from the queue: the heading step (skipped
// when turn_rate or elapsed_us is zero) uses the one shared multiplier on two halves
// of turn_rate * elapsed, then the iterative CORDIC runs, the five wheel products issue
// on the same multiplier, and sum and output follow. wheel_offset is written through
// csr (always ready) and should only change while idle.
module omni_wheel_inverse_kinematics_unit
   import owik_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   owik_req_if.sink    req_ch,
   owik_rsp_if.source  rsp_ch,
   owik_csr_if.sink    csr_ch
);

   logic         push;
   entry_type    push_entry;
   logic         pop;
   q_status_type q_status;
   entry_type    head;
   logic [14:0]  wheel_offset_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_offset_ff <= OFFSET_RESET;
      end else if (csr_ch.valid) begin
         wheel_offset_ff <= csr_ch.wheel_offset;
      end
   end

   owik_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   owik_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_status   (q_status),
      .head       (head)
   );

   owik_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .head         (head),
      .pop          (pop),
      .wheel_offset (wheel_offset_ff),
      .rsp          (rsp_ch)
   );

endmodule

`default_nettype wire
